[design/tdc_word_stream_decoder_assert.svh]
// ----------------------------------------------------------------------------
// TDC word stream decoder - assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TDC_WORD_STREAM_DECODER_ASSERT_SVH
`define TDC_WORD_STREAM_DECODER_ASSERT_SVH

`ifndef SYNTHESIS
// checked outside reset
`define TWSD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define TWSD_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TWSD_ASSERT(lbl, clk, rst_n, prop, msg)
`define TWSD_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

[design/tdc_wsd_pkg.sv]
// ----------------------------------------------------------------------------
// TDC word stream decoder - package
// Word kinds, tags, widths, time constants and the per-word decode record.
// ----------------------------------------------------------------------------
package tdc_wsd_pkg;

    localparam int SLOT_W = 5;
    localparam int CHAN_W = 8;
    localparam int TIME_W = 22;
    localparam int RAW_W  = 23;
    localparam int OFS_W  = 24;
    localparam int DIFF_W = 25;

    localparam logic [3:0] TAG_BLK_HDR = 4'd0;
    localparam logic [3:0] TAG_BLK_TRL = 4'd1;
    localparam logic [3:0] TAG_EVT_HDR = 4'd2;
    localparam logic [3:0] TAG_TRIG    = 4'd3;
    localparam logic [3:0] TAG_HIT     = 4'd7;

    localparam logic RES_HIT     = 1'b0;
    localparam logic RES_TRAILER = 1'b1;

    localparam logic [11:0]              COARSE_PS    = 12'd4000;
    localparam logic [10:0]              HALF_PS      = 11'd2000;
    localparam logic signed [OFS_W-1:0]  TRIG_BIAS_PS = 24'sd10000;
    localparam logic signed [DIFF_W-1:0] ROLLOVER_PS  = 25'sd4096000;
    localparam logic [TIME_W-1:0]        TIME_MAX     = 22'd4106034;

    typedef enum logic [2:0] {
        KIND_FILLER,
        KIND_TRAILER,
        KIND_EVENT,
        KIND_TRIG_LO,
        KIND_TRIG_HI,
        KIND_HIT
    } t_word_kind;

    typedef struct packed {
        t_word_kind                kind;
        logic [SLOT_W-1:0]         slot;
        logic [CHAN_W-1:0]         channel;
        logic                      edge_res;
        logic [RAW_W-1:0]          raw;
        logic signed [OFS_W-1:0]   cand;
    } t_mid;

    // floor(fine*2000/124.87) = 16*fine + 0, 1 or 2
    function automatic logic [10:0] fine_ps(input logic [6:0] fine);
        logic [1:0] extra;
        if (fine >= 7'd121) begin
            extra = 2'd2;
        end else if (fine >= 7'd61) begin
            extra = 2'd1;
        end else begin
            extra = 2'd0;
        end
        return {fine, 4'b0000} + {9'd0, extra};
    endfunction

    // groups 1 to 4 swap channel halves
    function automatic logic [CHAN_W-1:0] map_channel(input logic [2:0] grp,
                                                      input logic [4:0] chan);
        logic [4:0] c;
        c = chan;
        if (grp >= 3'd1 && grp <= 3'd4) begin
            c = {~chan[4], chan[3:0]};
        end
        return {grp, c};
    endfunction

endpackage

[design/tdc_wsd_decode.sv]
// ----------------------------------------------------------------------------
// TDC word stream decoder - word decode
// Classifies a readout word and forms the slot-independent hit time and the
// candidate trigger offset.
// ----------------------------------------------------------------------------
module tdc_wsd_decode (
    input  logic [31:0]       i_word,
    output tdc_wsd_pkg::t_mid o_mid
);

    logic [3:0]  tag;
    logic [21:0] coarse_ps;
    logic [21:0] lo_ps;

    assign tag       = i_word[30:27];
    assign coarse_ps = 22'(i_word[17:8]) * 22'(tdc_wsd_pkg::COARSE_PS);
    assign lo_ps     = 22'(i_word[9:0]) * 22'(tdc_wsd_pkg::COARSE_PS);

    always_comb begin
        o_mid.kind = tdc_wsd_pkg::KIND_FILLER;
        if (i_word[31]) begin
            case (tag)
                tdc_wsd_pkg::TAG_BLK_TRL: o_mid.kind = tdc_wsd_pkg::KIND_TRAILER;
                tdc_wsd_pkg::TAG_EVT_HDR: o_mid.kind = tdc_wsd_pkg::KIND_EVENT;
                tdc_wsd_pkg::TAG_TRIG:    o_mid.kind = tdc_wsd_pkg::KIND_TRIG_LO;
                tdc_wsd_pkg::TAG_HIT:     o_mid.kind = tdc_wsd_pkg::KIND_HIT;
                default:                  o_mid.kind = tdc_wsd_pkg::KIND_FILLER;
            endcase
        end else if (tag == tdc_wsd_pkg::TAG_BLK_HDR || tag == tdc_wsd_pkg::TAG_TRIG) begin
            o_mid.kind = tdc_wsd_pkg::KIND_TRIG_HI;
        end

        o_mid.slot     = i_word[26:22];
        o_mid.channel  = tdc_wsd_pkg::map_channel(i_word[26:24], i_word[23:19]);
        o_mid.edge_res = i_word[18];
        o_mid.raw      = 23'(coarse_ps)
                       + (i_word[7] ? 23'(tdc_wsd_pkg::HALF_PS) : 23'd0)
                       + 23'(tdc_wsd_pkg::fine_ps(i_word[6:0]));
        o_mid.cand     = $signed({2'b00, lo_ps}) - tdc_wsd_pkg::TRIG_BIAS_PS;
    end

endmodule

[design/tdc_word_stream_decoder.sv]
// ----------------------------------------------------------------------------
// TDC word stream decoder
// Takes one readout word per clock and returns a decoded hit (channel, edge,
// time in ps relative to the trigger) or a block trailer marker. Two register
// stages: the input word and the result. Decode, slot filter, state update
// and hit time arithmetic sit between them. A word is accepted every cycle
// while the result side takes results. A word held in the input stage is
// decoded into the result stage once that stage is free. While a result
// is stalled an empty input stage still takes one word, then the input
// stalls. The slot register is written through i_cfg_we.
// ----------------------------------------------------------------------------
`include "tdc_word_stream_decoder_assert.svh"

module tdc_word_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_data_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_result_kind,
    output logic [7:0]  o_channel,
    output logic        o_edge_res,
    output logic [21:0] o_time_ps
);

    logic                                  r_in_vld;
    logic [31:0]                           r_in_word;
    tdc_wsd_pkg::t_mid                     dec_mid;
    logic                                  r_out_vld;
    logic                                  r_out_kind;
    logic [tdc_wsd_pkg::CHAN_W-1:0]        r_out_channel;
    logic                                  r_out_edge;
    logic [tdc_wsd_pkg::TIME_W-1:0]        r_out_time;

    logic [tdc_wsd_pkg::SLOT_W-1:0]        r_slot_number;
    logic [tdc_wsd_pkg::SLOT_W-1:0]        r_event_slot;
    logic [tdc_wsd_pkg::SLOT_W-1:0]        n_event_slot;
    logic signed [tdc_wsd_pkg::OFS_W-1:0]  r_trig_cand;
    logic signed [tdc_wsd_pkg::OFS_W-1:0]  n_trig_cand;
    logic signed [tdc_wsd_pkg::OFS_W-1:0]  r_trig_offset;
    logic signed [tdc_wsd_pkg::OFS_W-1:0]  n_trig_offset;

    logic                                  n_emit;
    logic                                  n_kind;
    logic [tdc_wsd_pkg::CHAN_W-1:0]        n_channel;
    logic                                  n_edge;
    logic [tdc_wsd_pkg::TIME_W-1:0]        n_time;

    logic                                  en_out;
    logic                                  en_in;
    logic                                  match;
    logic signed [tdc_wsd_pkg::DIFF_W-1:0] diff;
    logic signed [tdc_wsd_pkg::DIFF_W-1:0] wrapped;

    assign en_out  = !r_out_vld || !i_stall;
    assign en_in   = !r_in_vld || en_out;
    assign o_stall = !en_in;

    tdc_wsd_decode u_decode (
        .i_word (r_in_word),
        .o_mid  (dec_mid)
    );

    assign match   = (r_event_slot == r_slot_number);
    assign diff    = $signed({2'b00, dec_mid.raw}) - $signed({r_trig_offset[23], r_trig_offset});
    assign wrapped = diff + tdc_wsd_pkg::ROLLOVER_PS;

    always_comb begin
        n_event_slot  = r_event_slot;
        n_trig_cand   = r_trig_cand;
        n_trig_offset = r_trig_offset;
        n_emit        = 1'b0;
        n_kind        = tdc_wsd_pkg::RES_HIT;
        n_channel     = '0;
        n_edge        = 1'b0;
        n_time        = '0;
        if (r_in_vld && en_out) begin
            case (dec_mid.kind)
                tdc_wsd_pkg::KIND_TRAILER: begin
                    n_emit = 1'b1;
                    n_kind = tdc_wsd_pkg::RES_TRAILER;
                end
                tdc_wsd_pkg::KIND_EVENT: begin
                    n_event_slot = dec_mid.slot;
                end
                tdc_wsd_pkg::KIND_TRIG_LO: begin
                    if (match) begin
                        n_trig_cand = dec_mid.cand;
                    end
                end
                tdc_wsd_pkg::KIND_TRIG_HI: begin
                    if (match) begin
                        n_trig_offset = r_trig_cand;
                    end
                end
                tdc_wsd_pkg::KIND_HIT: begin
                    if (match) begin
                        n_emit    = 1'b1;
                        n_channel = dec_mid.channel;
                        n_edge    = dec_mid.edge_res;
                        n_time    = diff[tdc_wsd_pkg::DIFF_W-1] ? wrapped[21:0] : diff[21:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld      <= 1'b0;
            r_out_vld     <= 1'b0;
            r_slot_number <= '0;
            r_event_slot  <= '0;
            r_trig_cand   <= -tdc_wsd_pkg::TRIG_BIAS_PS;
            r_trig_offset <= '0;
        end else begin
            if (en_in) begin
                r_in_vld <= i_valid;
            end
            if (en_out) begin
                r_out_vld <= n_emit;
            end
            if (i_cfg_we) begin
                r_slot_number <= i_cfg_data;
            end
            r_event_slot  <= n_event_slot;
            r_trig_cand   <= n_trig_cand;
            r_trig_offset <= n_trig_offset;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_in) begin
            r_in_word <= i_data_word;
        end
        if (en_out) begin
            r_out_kind    <= n_kind;
            r_out_channel <= n_channel;
            r_out_edge    <= n_edge;
            r_out_time    <= n_time;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_result_kind = r_out_kind;
    assign o_channel     = r_out_channel;
    assign o_edge_res    = r_out_edge;
    assign o_time_ps     = r_out_time;

    `TWSD_ASSERT_NR(a_rst_empty, i_clk, !i_rst_n |=> !o_valid && !o_stall, "pipeline not empty after reset")
    `TWSD_ASSERT(a_stall_full, i_clk, i_rst_n, o_stall |-> r_in_vld && r_out_vld, "input stalled with a free stage")
    `TWSD_ASSERT(a_in_hold, i_clk, i_rst_n, r_in_vld && !en_out |=> r_in_vld && $stable(r_in_word), "input word lost while held")
    `TWSD_ASSERT(a_trl_zero, i_clk, i_rst_n, o_valid && o_result_kind == tdc_wsd_pkg::RES_TRAILER |-> o_channel == 8'd0 && !o_edge_res && o_time_ps == 22'd0, "trailer result carries payload")
    `TWSD_ASSERT(a_time_rng, i_clk, i_rst_n, o_valid && o_result_kind == tdc_wsd_pkg::RES_HIT |-> o_time_ps <= tdc_wsd_pkg::TIME_MAX, "hit time out of range")

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TDC word stream decoder - testbench
// Sends readout words through the valid/stall input and predicts each decoded
// hit and block trailer from a local decoder model. Every taken result is
// compared field by field in order. Directed tests cover trigger offsets,
// rollover, channel remapping and slot filtering. A long output hold-off is
// then applied, and a random stream of well-formed blocks with noise follows
// under varying idle and stall rates.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT = 200000;
    localparam int FINE_NUM    = 200000;
    localparam int FINE_DEN    = 12487;
    localparam int HOLD_CYCLES = 150;
    localparam int SETTLE      = 8;
    localparam logic [2:0] SWAP_GRP_LO = 3'd1;
    localparam logic [2:0] SWAP_GRP_HI = 3'd4;

    typedef struct packed {
        logic                           kind;
        logic [tdc_wsd_pkg::CHAN_W-1:0] chan;
        logic                           edge_bit;
        logic [tdc_wsd_pkg::TIME_W-1:0] time_ps;
    } t_decode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [4:0]  i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [31:0] i_data_word = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_result_kind;
    logic [7:0]  o_channel;
    logic        o_edge_res;
    logic [21:0] o_time_ps;

    // decoder model state
    logic [tdc_wsd_pkg::SLOT_W-1:0] cfg_slot = '0;
    logic [tdc_wsd_pkg::SLOT_W-1:0] evt_slot = '0;
    logic [9:0]                     trig_lo_bits = '0;
    int                             trig_ofs = 0;
    t_decode                        pending_decodes[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int cycle_cnt = 0;
    int mismatch_cnt = 0;
    int words_sent = 0;
    int effective_words = 0;
    int hits_checked = 0;
    int trailers_checked = 0;
    int rollovers = 0;
    int slot_writes = 0;

    tdc_word_stream_decoder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_word   (i_data_word),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_result_kind (o_result_kind),
        .o_channel     (o_channel),
        .o_edge_res    (o_edge_res),
        .o_time_ps     (o_time_ps)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_cnt,
                     pending_decodes.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver stall, with a long hold-off when requested
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("[%0t] mismatch %s: expected 0x%0h got 0x%0h", $time, what, want, got);
        mismatch_cnt++;
    endtask

    always @(posedge i_clk) begin : result_check
        t_decode want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_decodes.size() == 0) begin
                report_mismatch("result with none pending", 32'd0, {31'd0, o_result_kind});
            end else begin
                want = pending_decodes.pop_front();
                if (o_result_kind !== want.kind)
                    report_mismatch("result_kind", want.kind, o_result_kind);
                if (o_channel !== want.chan)
                    report_mismatch("channel", want.chan, o_channel);
                if (o_edge_res !== want.edge_bit)
                    report_mismatch("edge_res", want.edge_bit, o_edge_res);
                if (o_time_ps !== want.time_ps)
                    report_mismatch("time_ps", want.time_ps, o_time_ps);
                if (want.kind == tdc_wsd_pkg::RES_TRAILER) trailers_checked++;
                else hits_checked++;
            end
        end
    end

    task automatic predict_decode(input logic [31:0] w);
        logic [3:0]        tag;
        logic              match;
        logic [2:0]        grp;
        logic [4:0]        ch;
        int                raw;
        t_decode           d;
        tag = w[30:27];
        match = (evt_slot == cfg_slot);
        d = '0;
        if (!w[31]) begin
            if ((tag == tdc_wsd_pkg::TAG_BLK_HDR || tag == tdc_wsd_pkg::TAG_TRIG) && match) begin
                trig_ofs = int'(trig_lo_bits) * int'(tdc_wsd_pkg::COARSE_PS)
                         - int'(tdc_wsd_pkg::TRIG_BIAS_PS);
                effective_words++;
            end
            return;
        end
        case (tag)
            tdc_wsd_pkg::TAG_BLK_TRL: begin
                d.kind = tdc_wsd_pkg::RES_TRAILER;
                pending_decodes.push_back(d);
                effective_words++;
            end
            tdc_wsd_pkg::TAG_EVT_HDR: begin
                evt_slot = w[26:22];
                effective_words++;
            end
            tdc_wsd_pkg::TAG_TRIG: begin
                if (match) begin
                    trig_lo_bits = w[9:0];
                    effective_words++;
                end
            end
            tdc_wsd_pkg::TAG_HIT: begin
                if (match) begin
                    grp = w[26:24];
                    ch = w[23:19];
                    if (grp >= SWAP_GRP_LO && grp <= SWAP_GRP_HI)
                        ch = (ch <= 5'd15) ? ch + 5'd16 : ch - 5'd16;
                    raw = int'(w[17:8]) * int'(tdc_wsd_pkg::COARSE_PS)
                        + int'(w[7]) * int'(tdc_wsd_pkg::HALF_PS)
                        + int'(w[6:0]) * FINE_NUM / FINE_DEN;
                    if (raw < trig_ofs) begin
                        raw += int'(tdc_wsd_pkg::ROLLOVER_PS);
                        rollovers++;
                    end
                    d.kind = tdc_wsd_pkg::RES_HIT;
                    d.chan = {grp, ch};
                    d.edge_bit = w[18];
                    d.time_ps = tdc_wsd_pkg::TIME_W'(raw - trig_ofs);
                    pending_decodes.push_back(d);
                    effective_words++;
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_word(input logic [31:0] w);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_data_word <= w;
        do @(posedge i_clk); while (o_stall);
        words_sent++;
        predict_decode(w);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_decodes.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_slot(input logic [4:0] s);
        drain();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= s;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_slot = s;
        slot_writes++;
    endtask

    function automatic logic [31:0] mk_hit(input logic [2:0] grp, input logic [4:0] ch,
                                           input logic edge_bit, input logic [9:0] coarse,
                                           input logic half, input logic [6:0] fine);
        return {1'b1, tdc_wsd_pkg::TAG_HIT, grp, ch, edge_bit, coarse, half, fine};
    endfunction

    function automatic logic [31:0] rand_hit();
        return {1'b1, tdc_wsd_pkg::TAG_HIT, 27'($urandom)};
    endfunction

    function automatic logic [31:0] mk_evt(input logic [4:0] slot);
        return {1'b1, tdc_wsd_pkg::TAG_EVT_HDR, slot, 22'($urandom)};
    endfunction

    function automatic logic [31:0] mk_trig_lo(input logic [9:0] v);
        return {1'b1, tdc_wsd_pkg::TAG_TRIG, 17'($urandom), v};
    endfunction

    function automatic logic [31:0] mk_trig_hi(input logic [3:0] tag);
        return {1'b0, tag, 27'($urandom)};
    endfunction

    function automatic logic [31:0] mk_blk_hdr();
        return {1'b1, tdc_wsd_pkg::TAG_BLK_HDR, 27'($urandom)};
    endfunction

    function automatic logic [31:0] mk_trailer();
        return {1'b1, tdc_wsd_pkg::TAG_BLK_TRL, 27'($urandom)};
    endfunction

    function automatic logic [31:0] mk_filler();
        logic [31:0] w;
        logic [3:0]  tag;
        logic        known;
        logic        trig_hi;
        forever begin
            w = $urandom;
            tag = w[30:27];
            known = (tag == tdc_wsd_pkg::TAG_BLK_HDR) || (tag == tdc_wsd_pkg::TAG_BLK_TRL)
                 || (tag == tdc_wsd_pkg::TAG_EVT_HDR) || (tag == tdc_wsd_pkg::TAG_TRIG)
                 || (tag == tdc_wsd_pkg::TAG_HIT);
            trig_hi = (tag == tdc_wsd_pkg::TAG_BLK_HDR) || (tag == tdc_wsd_pkg::TAG_TRIG);
            if (w[31] && !known)
                return w;
            if (!w[31] && !trig_hi)
                return w;
        end
    endfunction

    function automatic logic [9:0] pick_trig();
        case ($urandom_range(0, 9))
            0: return 10'd0;
            1: return 10'd1023;
            default: return 10'($urandom);
        endcase
    endfunction

    function automatic logic [4:0] pick_slot();
        case ($urandom_range(0, 3))
            0: return 5'd0;
            1: return 5'd31;
            default: return 5'($urandom);
        endcase
    endfunction

    task automatic test_reset_state();
        // hit before any trigger uses a zero offset
        send_word(mk_hit(3'd0, 5'd5, 1'b1, 10'd10, 1'b0, 7'd0));
        send_word(mk_blk_hdr());
        send_word(mk_trailer());
    endtask

    task automatic test_trigger_offset();
        send_word(mk_evt(5'd0));
        send_word(mk_trig_lo(10'd0));
        send_word(mk_trig_hi(tdc_wsd_pkg::TAG_BLK_HDR));
        send_word(mk_hit(3'd0, 5'd0, 1'b0, 10'd1023, 1'b1, 7'd127));
        send_word(mk_hit(3'd0, 5'd0, 1'b0, 10'd0, 1'b0, 7'd0));
        send_word(mk_trig_lo(10'd1023));
        send_word(mk_trig_hi(tdc_wsd_pkg::TAG_TRIG));
        send_word(mk_hit(3'd0, 5'd0, 1'b0, 10'd0, 1'b0, 7'd0));
        // exactly on the offset: no rollover, zero time
        send_word(mk_hit(3'd0, 5'd0, 1'b1, 10'd1020, 1'b1, 7'd0));
    endtask

    task automatic test_channel_map();
        send_word(mk_hit(3'd1, 5'd0, 1'b0, 10'd512, 1'b0, 7'd61));
        send_word(mk_hit(3'd4, 5'd15, 1'b1, 10'd1, 1'b1, 7'd121));
        send_word(mk_hit(3'd5, 5'd16, 1'b0, 10'd700, 1'b0, 7'd60));
        send_word(mk_hit(3'd7, 5'd31, 1'b1, 10'd1023, 1'b1, 7'd120));
        send_word(mk_hit(3'd0, 5'd31, 1'b1, 10'd3, 1'b0, 7'd1));
        send_word(mk_hit(3'd2, 5'd16, 1'b0, 10'd1022, 1'b1, 7'd127));
    endtask

    task automatic test_slot_filter();
        // words of another slot are dropped, trailers are not
        send_word(mk_evt(5'd31));
        send_word(mk_trig_lo(10'd5));
        send_word(mk_trig_hi(tdc_wsd_pkg::TAG_TRIG));
        send_word(rand_hit());
        send_word(mk_trailer());
        send_word(mk_filler());
        send_word(mk_filler());
        write_slot(5'd31);
        send_word(rand_hit());
        write_slot(5'd0);
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        send_word(mk_evt(cfg_slot));
        send_word(mk_trig_lo(pick_trig()));
        send_word(mk_trig_hi(tdc_wsd_pkg::TAG_TRIG));
        hold_req = 1'b1;
        repeat (40) send_word(rand_hit());
        drain();
        send_idle_pct = 29;
    endtask

    task automatic run_phase(input int n, input int sp, input int rp);
        int goal;
        send_idle_pct = sp;
        recv_idle_pct = rp;
        write_slot(5'($urandom));
        goal = words_sent + n;
        while (words_sent < goal) begin
            if ($urandom_range(0, 7) == 0) write_slot(pick_slot());
            send_word(mk_blk_hdr());
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(1, 4)) begin
                        case ($urandom_range(0, 3))
                            0: send_word(mk_filler());
                            1: send_word($urandom);
                            2: send_word(rand_hit());
                            default: send_word(mk_trig_hi(tdc_wsd_pkg::TAG_BLK_HDR));
                        endcase
                    end
                end
                send_word(mk_evt(($urandom_range(0, 9) < 8) ? cfg_slot : 5'($urandom)));
                if ($urandom_range(0, 9) != 0) send_word(mk_trig_lo(pick_trig()));
                if ($urandom_range(0, 9) != 0)
                    send_word(mk_trig_hi($urandom_range(0, 1) ? tdc_wsd_pkg::TAG_BLK_HDR
                                                              : tdc_wsd_pkg::TAG_TRIG));
                repeat ($urandom_range(0, 6)) send_word(rand_hit());
            end
            send_word(mk_trailer());
        end
    endtask

    task automatic test_random_stream();
        run_phase(290, 29, 61);
        run_phase(290, 61, 29);
        run_phase(290, 0, 0);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 29;
        recv_idle_pct = 61;
        test_reset_state();
        test_trigger_offset();
        test_channel_map();
        test_slot_filter();
        test_backpressure();
        test_random_stream();
        drain();
        $display("Sent %0d words (%0d acted on), %0d slot settings, %0d-cycle output hold",
                 words_sent, effective_words, slot_writes, HOLD_CYCLES);
        $display("Checked %0d hits (%0d with rollover) and %0d trailers, %0d mismatches",
                 hits_checked, rollovers, trailers_checked, mismatch_cnt);
        if (mismatch_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
